FILE: design/reader_command_framer_crc16_core_assert.svh
// Assertion macros for the reader command framer.
// Included by the top level; expects a clock named clk and a reset named arst_n.
`ifndef READER_COMMAND_FRAMER_CRC16_CORE_ASSERT_SVH
`define READER_COMMAND_FRAMER_CRC16_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCF_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RCF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/rcf_pkg.sv
// Shared types and constants for the reader command framer.
// Used by the top level and the testbench.
package rcf_pkg;

	localparam logic [7:0]  HEADER_BYTE   = 8'hFF;
	localparam logic [15:0] POLY_RESET    = 16'h1021;
	localparam logic [15:0] INIT_RESET    = 16'hFFFF;

	localparam logic CMD_START   = 1'b0;
	localparam logic CMD_PAYLOAD = 1'b1;

	localparam logic CFG_POLYNOMIAL = 1'b0;
	localparam logic CFG_INITIAL    = 1'b1;

	typedef struct packed {
		logic       cmd;
		logic [7:0] opcode;
		logic [7:0] payload_length;
		logic [7:0] payload_byte;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_end;
	} out_t;

	typedef enum logic [2:0] {
		ST_ITEM,
		ST_LEN,
		ST_OPC,
		ST_CRC_HI,
		ST_CRC_LO
	} state_t;

endpackage

FILE: design/rcf_crc_byte.sv
// One byte of the augmented bitwise CRC-16, MSB first, with a programmable polynomial.
// Pure combinational logic; no package dependencies.
module rcf_crc_byte (
	input  logic [15:0] crc_in,
	input  logic [15:0] poly,
	input  logic [7:0]  data,
	output logic [15:0] crc_out
);

	always_comb begin
		logic [15:0] c;
		logic        fb;
		c = crc_in;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15];
			c = {c[14:0], data[i]};
			if (fb) begin
				c = c ^ poly;
			end
		end
		crc_out = c;
	end

endmodule

FILE: design/reader_command_framer_crc16_core.sv
// Serial command framer with CRC-16 trailer. A start word is followed on the output by
// 0xFF, the length (saturated to MAX_PAYLOAD) and the opcode, and by the two CRC bytes at
// once when the length is zero; each payload word of an open frame gives one output word,
// and the last one two more for the CRC. One output word leaves per cycle from a single
// output register while the receiver is ready, so a stream of payload words runs at one
// word per cycle; the input is held while a start word's header (and, with an empty
// payload, its CRC) bursts out, and while the last payload word's CRC bytes leave.
module reader_command_framer_crc16_core #(
	parameter int MAX_PAYLOAD = 251
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rcf_pkg::in_t       in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output rcf_pkg::out_t      out_data,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data
);

	localparam int RemW = $clog2(MAX_PAYLOAD + 1);

	logic [15:0] poly_q, init_q;

	logic          s1_valid;
	rcf_pkg::in_t  s1_data;

	rcf_pkg::state_t state_q, state_nxt;
	logic [15:0]     crc_q;
	logic [RemW-1:0] rem_q, len_q;
	logic            open_q;
	logic [7:0]      opcode_q;

	logic          out_valid_q;
	rcf_pkg::out_t out_q;

	logic          advance, s1_take;
	logic          emit, emit_end;
	logic [7:0]    emit_byte;
	logic [7:0]    feed_byte;
	logic [15:0]   crc_feed_out;
	logic          pay_ok;
	logic [RemW-1:0] len_sat;

	assign advance  = !out_valid_q || out_ready;
	assign s1_take  = advance && (state_q == rcf_pkg::ST_ITEM) && s1_valid;
	assign in_ready = !s1_valid || s1_take;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign pay_ok    = open_q && (rem_q != '0);

	assign len_sat = (s1_data.payload_length > 8'(MAX_PAYLOAD)) ? RemW'(MAX_PAYLOAD)
		: RemW'(s1_data.payload_length);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= rcf_pkg::POLY_RESET;
			init_q <= rcf_pkg::INIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				rcf_pkg::CFG_POLYNOMIAL: poly_q <= cfg_data;
				rcf_pkg::CFG_INITIAL:    init_q <= cfg_data;
				default:                 ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_ready) begin
			s1_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			s1_data <= in_data;
		end
	end

	// The running CRC is fed either the held length, the held opcode or a payload byte.
	always_comb begin
		case (state_q)
			rcf_pkg::ST_LEN: feed_byte = 8'(len_q);
			rcf_pkg::ST_OPC: feed_byte = opcode_q;
			default:         feed_byte = s1_data.payload_byte;
		endcase
	end

	rcf_crc_byte u_crc (
		.crc_in  (crc_q),
		.poly    (poly_q),
		.data    (feed_byte),
		.crc_out (crc_feed_out)
	);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			rcf_pkg::ST_ITEM: begin
				if (s1_valid) begin
					if (s1_data.cmd == rcf_pkg::CMD_START) begin
						state_nxt = rcf_pkg::ST_LEN;
					end else if (pay_ok && (rem_q == RemW'(1))) begin
						state_nxt = rcf_pkg::ST_CRC_HI;
					end
				end
			end
			rcf_pkg::ST_LEN:    state_nxt = rcf_pkg::ST_OPC;
			rcf_pkg::ST_OPC:    state_nxt = (len_q == '0) ? rcf_pkg::ST_CRC_HI
				: rcf_pkg::ST_ITEM;
			rcf_pkg::ST_CRC_HI: state_nxt = rcf_pkg::ST_CRC_LO;
			rcf_pkg::ST_CRC_LO: state_nxt = rcf_pkg::ST_ITEM;
			default:            state_nxt = rcf_pkg::ST_ITEM;
		endcase
	end

	always_comb begin
		emit      = 1'b0;
		emit_end  = 1'b0;
		emit_byte = s1_data.payload_byte;
		case (state_q)
			rcf_pkg::ST_ITEM: begin
				if (s1_valid) begin
					if (s1_data.cmd == rcf_pkg::CMD_START) begin
						emit      = 1'b1;
						emit_byte = rcf_pkg::HEADER_BYTE;
					end else begin
						emit = pay_ok;
					end
				end
			end
			rcf_pkg::ST_LEN: begin
				emit      = 1'b1;
				emit_byte = 8'(len_q);
			end
			rcf_pkg::ST_OPC: begin
				emit      = 1'b1;
				emit_byte = opcode_q;
			end
			rcf_pkg::ST_CRC_HI: begin
				emit      = 1'b1;
				emit_byte = crc_q[15:8];
			end
			rcf_pkg::ST_CRC_LO: begin
				emit      = 1'b1;
				emit_byte = crc_q[7:0];
				emit_end  = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rcf_pkg::ST_ITEM;
			crc_q       <= rcf_pkg::INIT_RESET;
			rem_q       <= '0;
			open_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			state_q     <= state_nxt;
			out_valid_q <= emit;
			case (state_q)
				rcf_pkg::ST_ITEM: begin
					if (s1_valid) begin
						if (s1_data.cmd == rcf_pkg::CMD_START) begin
							crc_q  <= init_q;
							open_q <= 1'b0;
							rem_q  <= '0;
						end else if (pay_ok) begin
							crc_q <= crc_feed_out;
							rem_q <= rem_q - RemW'(1);
							if (rem_q == RemW'(1)) begin
								open_q <= 1'b0;
							end
						end else begin
							open_q <= 1'b0;
							rem_q  <= '0;
						end
					end
				end
				rcf_pkg::ST_LEN: crc_q <= crc_feed_out;
				rcf_pkg::ST_OPC: begin
					crc_q <= crc_feed_out;
					if (len_q != '0) begin
						open_q <= 1'b1;
						rem_q  <= len_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.out_byte  <= emit_byte;
			out_q.frame_end <= emit_end;
		end
		if (s1_take && (s1_data.cmd == rcf_pkg::CMD_START)) begin
			len_q    <= len_sat;
			opcode_q <= s1_data.opcode;
		end
	end

`include "reader_command_framer_crc16_core_assert.svh"

	`RCF_ASSERT_SAME(a_end_closes_frame, out_valid_q && out_q.frame_end, (state_q == rcf_pkg::ST_ITEM) && !open_q, "frame end shown while a frame is still open")
	`RCF_ASSERT_NEXT(a_crc_hi_then_byte, (state_q == rcf_pkg::ST_CRC_HI) && advance, out_valid_q && !out_q.frame_end && (state_q == rcf_pkg::ST_CRC_LO), "CRC high byte not followed by the low byte")
	`RCF_ASSERT_SAME(a_open_has_count, open_q, rem_q != '0, "open frame with no payload bytes left")

endmodule

FILE: tb/tb_reader_command_framer_crc16_core.sv
// Self-checking testbench for reader_command_framer_crc16_core: frames and CRC trailers
// are predicted in a scoreboard class and compared word by word with the output stream.
// Depends on rcf_pkg and the framer RTL only.
module tb_reader_command_framer_crc16_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_PAYLOAD   = 251;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 300;

	class frame_byte_checker;
		logic [15:0] crc_poly;
		logic [15:0] crc_init;
		logic [15:0] crc_value;
		logic [7:0]  bytes_left;
		bit          in_frame;
		rcf_pkg::out_t expected_bytes[$];
		int          errors;

		function new();
			crc_poly = rcf_pkg::POLY_RESET;
			crc_init = rcf_pkg::INIT_RESET;
			crc_value = rcf_pkg::INIT_RESET;
			bytes_left = '0;
			in_frame = 1'b0;
			errors = 0;
		endfunction

		function void load_config(logic idx, logic [15:0] value);
			if (idx == rcf_pkg::CFG_POLYNOMIAL) begin
				crc_poly = value;
			end else begin
				crc_init = value;
			end
		endfunction

		// Augmented form: data bits enter at bit 0, no zero flush at the end.
		function void crc_shift_byte(logic [7:0] b);
			logic fb;
			for (int i = 7; i >= 0; i--) begin
				fb = crc_value[15];
				crc_value = {crc_value[14:0], b[i]};
				if (fb) begin
					crc_value = crc_value ^ crc_poly;
				end
			end
		endfunction

		function void push_byte(logic [7:0] b, logic last);
			rcf_pkg::out_t o;
			o.out_byte = b;
			o.frame_end = last;
			expected_bytes.push_back(o);
		endfunction

		function void close_frame();
			push_byte(crc_value[15:8], 1'b0);
			push_byte(crc_value[7:0], 1'b1);
			in_frame = 1'b0;
			bytes_left = '0;
		endfunction

		function void note_word(rcf_pkg::in_t w);
			logic [7:0] len;
			if (w.cmd == rcf_pkg::CMD_START) begin
				len = (w.payload_length > MAX_PAYLOAD) ? 8'(MAX_PAYLOAD) : w.payload_length;
				crc_value = crc_init;
				crc_shift_byte(len);
				crc_shift_byte(w.opcode);
				push_byte(rcf_pkg::HEADER_BYTE, 1'b0);
				push_byte(len, 1'b0);
				push_byte(w.opcode, 1'b0);
				if (len == 0) begin
					close_frame();
				end else begin
					in_frame = 1'b1;
					bytes_left = len;
				end
			end else if (!in_frame || bytes_left == 0) begin
				in_frame = 1'b0;
				bytes_left = '0;
			end else begin
				crc_shift_byte(w.payload_byte);
				push_byte(w.payload_byte, 1'b0);
				bytes_left = bytes_left - 8'd1;
				if (bytes_left == 0) begin
					close_frame();
				end
			end
		endfunction

		task report(string msg);
			$display("%0t ns: mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_word(rcf_pkg::out_t got);
			rcf_pkg::out_t want;
			if (expected_bytes.size() == 0) begin
				report($sformatf("unexpected word out_byte=%h frame_end=%b",
					got.out_byte, got.frame_end));
			end else begin
				want = expected_bytes.pop_front();
				if (got.out_byte !== want.out_byte) begin
					report($sformatf("out_byte %h, expected %h", got.out_byte, want.out_byte));
				end
				if (got.frame_end !== want.frame_end) begin
					report($sformatf("frame_end %b, expected %b (out_byte %h)",
						got.frame_end, want.frame_end, want.out_byte));
				end
			end
		endtask
	endclass

	logic          clk;
	logic          arst_n;
	logic          in_valid;
	logic          in_ready;
	rcf_pkg::in_t  in_data;
	logic          out_valid;
	logic          out_ready;
	rcf_pkg::out_t out_data;
	logic          cfg_we;
	logic          cfg_index;
	logic [15:0]   cfg_data;

	frame_byte_checker sb = new();
	int burst_left = 0;
	bit hold_off_go = 1'b0;

	reader_command_framer_crc16_core #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb_reader_command_framer_crc16_core: FAIL");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_word(out_data);
		end
	end

	// Receiver: random stall modes, plus one long hold-off when asked for.
	initial begin
		int mode;
		int mode_left;
		mode = 0;
		mode_left = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_go) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off_go = 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 2);
					mode_left = $urandom_range(20, 80);
				end
				mode_left--;
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	function automatic rcf_pkg::in_t start_word(logic [7:0] op, logic [7:0] len);
		rcf_pkg::in_t w;
		w.cmd = rcf_pkg::CMD_START;
		w.opcode = op;
		w.payload_length = len;
		w.payload_byte = 8'($urandom);
		return w;
	endfunction

	function automatic rcf_pkg::in_t payload_word(logic [7:0] b);
		rcf_pkg::in_t w;
		w.cmd = rcf_pkg::CMD_PAYLOAD;
		w.opcode = 8'($urandom);
		w.payload_length = 8'($urandom);
		w.payload_byte = b;
		return w;
	endfunction

	// Sender works in bursts; each burst is preceded by a gap that may be empty.
	task automatic send_word(rcf_pkg::in_t w);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		sb.note_word(w);
		burst_left--;
	endtask

	// Dropped payload words can still sit inside the block, so allow extra cycles.
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (sb.expected_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_crc(logic [15:0] poly, logic [15:0] init);
		wait_idle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= rcf_pkg::CFG_POLYNOMIAL;
		cfg_data <= poly;
		@(negedge clk);
		cfg_index <= rcf_pkg::CFG_INITIAL;
		cfg_data <= init;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.load_config(rcf_pkg::CFG_POLYNOMIAL, poly);
		sb.load_config(rcf_pkg::CFG_INITIAL, init);
	endtask

	task automatic run_directed();
		send_word(start_word(8'h00, 8'd0));
		send_word(start_word(8'hFF, 8'd0));
		// Payload with no open frame is dropped.
		send_word(payload_word(8'hAA));
		send_word(start_word(8'h5A, 8'd1));
		send_word(payload_word(8'h00));
		send_word(start_word(8'hA5, 8'd2));
		send_word(payload_word(8'hFF));
		send_word(payload_word(8'h80));
		send_word(payload_word(8'h01));
		// Oversized length saturates; the frame is then abandoned by a new start.
		send_word(start_word(8'h3C, 8'd255));
		send_word(payload_word(8'h12));
		send_word(payload_word(8'h34));
		send_word(start_word(8'hC3, 8'd3));
		send_word(payload_word(8'h01));
		send_word(payload_word(8'h02));
		send_word(payload_word(8'h03));
		send_word(start_word(8'h7E, 8'd252));
		send_word(start_word(8'h81, 8'd0));
		send_word(start_word(8'h00, 8'd251));
		send_word(payload_word(8'h55));
		send_word(start_word(8'h24, 8'd1));
		send_word(payload_word(8'hDB));
	endtask

	task automatic run_frames(int n);
		int sent;
		int r;
		int len;
		int count;
		sent = 0;
		while (sent < n) begin
			r = $urandom_range(0, 99);
			if (r < 80) begin
				r = $urandom_range(0, 19);
				if (r < 14) begin
					len = $urandom_range(0, 4);
				end else if (r < 19) begin
					len = $urandom_range(5, 16);
				end else begin
					len = $urandom_range(17, 40);
				end
				send_word(start_word(8'($urandom), 8'(len)));
				sent++;
				count = len;
				// Now and then cut the frame short so the next start abandons it.
				if ($urandom_range(0, 9) == 0) begin
					count = $urandom_range(0, len);
				end
				repeat (count) begin
					send_word(payload_word(8'($urandom)));
					sent++;
				end
				if ($urandom_range(0, 19) == 0) begin
					send_word(payload_word(8'($urandom)));
				end
			end else if (r < 92) begin
				send_word(payload_word(8'($urandom)));
			end else begin
				send_word(start_word(8'($urandom), 8'($urandom)));
				sent++;
			end
		end
	endtask

	task automatic run_full_frame();
		send_word(start_word(8'($urandom), 8'($urandom_range(MAX_PAYLOAD, 255))));
		repeat (MAX_PAYLOAD) send_word(payload_word(8'($urandom)));
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = rcf_pkg::CFG_POLYNOMIAL;
		cfg_data = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		run_directed();
		run_frames(60);

		set_crc(16'h0000, 16'h0000);
		run_frames(50);

		set_crc(16'hFFFF, 16'hFFFF);
		hold_off_go = 1'b1;
		run_frames(50);

		set_crc(16'h8005, 16'h0000);
		run_full_frame();
		run_frames(20);

		set_crc(16'($urandom), 16'($urandom));
		run_frames(40);

		set_crc(rcf_pkg::POLY_RESET, rcf_pkg::INIT_RESET);
		run_frames(30);

		wait_idle();
		if (sb.errors == 0) begin
			$display("tb_reader_command_framer_crc16_core: PASS");
		end else begin
			$display("tb_reader_command_framer_crc16_core: FAIL");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+design
design/rcf_pkg.sv
design/rcf_crc_byte.sv
design/reader_command_framer_crc16_core.sv
tb/tb_reader_command_framer_crc16_core.sv
